FILE: hw/rtl/dq_pkg.sv
package dq_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int OP_W       = 3;
   localparam int ERR_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4
   } opcode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_RANGE = 2'd2,
      ERR_FULL  = 2'd3
   } error_type;

   // Per-cell controls for one clock edge.
   typedef struct packed {
      logic shift_up;    // take the neighbour nearer the front
      logic shift_down;  // take the neighbour nearer the back
      logic load;        // take the pushed element
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/dq_req_if.sv
interface dq_req_if;
   import dq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           opcode;
   logic [DATA_WIDTH-1:0]     push_value;
   logic [IDX_W-1:0]          position;

   modport source (output valid, output opcode, output push_value, output position,
                   input ready);
   modport sink   (input valid, input opcode, input push_value, input position,
                   output ready);
endinterface

FILE: hw/rtl/dq_rsp_if.sv
interface dq_rsp_if;
   import dq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [DATA_WIDTH-1:0]     read_value;
   logic [ERR_W-1:0]          error_code;
   logic [CNT_W-1:0]          fill_count;

   modport source (output valid, output read_value, output error_code, output fill_count,
                   input ready);
   modport sink   (input valid, input read_value, input error_code, input fill_count,
                   output ready);
endinterface

FILE: hw/rtl/double_ended_queue.sv
// Channel   Beat direction   Contents
// req_bus   in               opcode, push_value, position
// rsp_bus   out              read_value, error_code, fill_count
//
// One operation is taken per clock cycle; its result beat appears in the
// response register on the following cycle. The whole row of cells shifts,
// loads or holds all together, in step, so the row keeps up with the rate of one beat a cycle.
// Reset clears the element count and the response valid flag; cell contents
// are not reset. A stalled response holds the request side back until it is taken.
module double_ended_queue (
   input logic clock,
   input logic reset,
   dq_req_if.sink   req_bus,
   dq_rsp_if.source rsp_bus
);
   import dq_pkg::*;

   // Element i of the queue, counted from the front, always lives in cell i.
   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   cell_ctrl_type         cell_ctrl [CAPACITY];

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [DATA_WIDTH-1:0] rsp_value_in;
   error_type             rsp_error_ff;
   error_type             rsp_error_in;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  accept;
   opcode_type            op;
   logic                  is_full;
   logic                  is_empty;
   logic                  do_push_front;
   logic                  do_push_back;
   logic                  do_pop_front;
   logic [IDX_W-1:0]      read_index;
   logic [IDX_W-1:0]      back_index;

   // A new beat is taken whenever the response register is free or being emptied.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign op            = opcode_type'(req_bus.opcode);

   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign back_index = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      do_push_front = 1'b0;
      do_push_back  = 1'b0;
      do_pop_front  = 1'b0;
      count_in      = count_ff;
      rsp_error_in  = ERR_OK;
      read_index    = '0;
      rsp_value_in  = '0;
      case (op)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               rsp_error_in = ERR_FULL;
            end else begin
               do_push_front = accept;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (is_full) begin
               rsp_error_in = ERR_FULL;
            end else begin
               do_push_back = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               rsp_error_in = ERR_EMPTY;
            end else begin
               do_pop_front = accept;
               read_index   = '0;
               rsp_value_in = cell_data[read_index];
               count_in     = count_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               rsp_error_in = ERR_EMPTY;
            end else begin
               read_index   = back_index;
               rsp_value_in = cell_data[read_index];
               count_in     = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (CNT_W'(req_bus.position) >= count_ff) begin
               rsp_error_in = ERR_RANGE;
            end else begin
               read_index   = req_bus.position;
               rsp_value_in = cell_data[read_index];
            end
         end
         default: begin
         end
      endcase
   end

   // The row of cells. Cell 0 takes the pushed element on a front push; the
   // last cell simply refills itself on a front pop, as that slot becomes free.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] nearer_front;
      logic [DATA_WIDTH-1:0] nearer_back;

      if (i == 0) begin : g_first
         assign nearer_front = req_bus.push_value;
      end else begin : g_inner
         assign nearer_front = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign nearer_back = cell_data[i];
      end else begin : g_body
         assign nearer_back = cell_data[i+1];
      end

      assign cell_ctrl[i].shift_up   = do_push_front;
      assign cell_ctrl[i].shift_down = do_pop_front;
      assign cell_ctrl[i].load       = do_push_back && (count_ff[IDX_W-1:0] == IDX_W'(i));

      dq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .from_front (nearer_front),
         .from_back  (nearer_back),
         .load_value (req_bus.push_value),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload is only loaded with a new beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_value_ff;
   assign rsp_bus.error_code = rsp_error_ff;
   assign rsp_bus.fill_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      accept && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
      |=> rsp_bus.valid && rsp_bus.error_code == ERR_FULL && $stable(count_ff))
      else $error("push into a full queue not refused");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty && (op == OP_POP_FRONT || op == OP_POP_BACK)
      |=> rsp_bus.valid && rsp_bus.error_code == ERR_EMPTY && rsp_bus.read_value == '0)
      else $error("pop from an empty queue not refused");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> $stable(count_ff))
      else $error("queue state moved while the response was stalled");
`endif

endmodule

FILE: hw/rtl/dq_cell.sv
module dq_cell (
   input  logic                          clock,
   input  dq_pkg::cell_ctrl_type         ctrl,
   input  logic [dq_pkg::DATA_WIDTH-1:0] from_front,
   input  logic [dq_pkg::DATA_WIDTH-1:0] from_back,
   input  logic [dq_pkg::DATA_WIDTH-1:0] load_value,
   output logic [dq_pkg::DATA_WIDTH-1:0] data
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // Loading wins over shifting; only one is ever asked for at a time.
   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_value;
      end else if (ctrl.shift_up) begin
         data_in = from_front;
      end else if (ctrl.shift_down) begin
         data_in = from_back;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
